>>> src/rbc_pkg.sv
// Shared types, constants and helpers for the ray budget controller.
`timescale 1ns / 1ps

package rbc_pkg;

    // Operation codes carried on the input tuser
    typedef enum logic [2:0] {
        OP_BEGIN  = 3'd0,
        OP_END    = 3'd1,
        OP_QUERY  = 3'd2,
        OP_SPEND  = 3'd3,
        OP_BORROW = 3'd4,
        OP_SET    = 3'd5
    } t_op;

    localparam logic [23:0] BUDGET_RESET = 24'd4000000;
    localparam logic [24:0] BUDGET_MIN   = 25'd500000;
    localparam logic [24:0] BUDGET_MAX   = 25'd16000000;
    localparam logic [19:0] TARGET_RESET = 20'd16667;

    // floor(x / 5) == (x * DIV5_RECIP) >> 34 for every 32-bit x
    localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV5_SHIFT = 34;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 128;

    // Request held in the input register; time thresholds already resolved
    typedef struct packed {
        t_op         op;
        logic [23:0] ray_count;
        logic [23:0] new_budget;
        logic        slow;
        logic        fast;
    } t_req;

    // Result fields, state after the request
    typedef struct packed {
        logic        may_trace;
        logic [23:0] budget_now;
        logic [31:0] rays_spent;
        logic [31:0] debt_now;
        logic [31:0] frame_count;
    } t_rsp;

    // Add with saturation at the 32-bit ceiling
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [23:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {9'd0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

endpackage

>>> src/rbc_in_stage.sv
// Input register of the ray budget controller with frame time threshold compare.
`timescale 1ns / 1ps

module rbc_in_stage
    import rbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [19:0]          i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_op,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic                 i_adv,
    output logic                 o_req_valid,
    output t_req                 o_req
);

    logic [19:0] r_target;
    logic        r_valid;
    t_req        r_req;
    t_req        n_req;
    logic [23:0] ftime_x10;
    logic [23:0] tgt_x11;
    logic [23:0] tgt_x8;
    logic [19:0] ftime;

    // Hold the target register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
        end else if (i_cfg_wr_en) begin
            r_target <= i_cfg_wr_data;
        end
    end

    // Resolve the slow and fast thresholds before the request is stored
    always_comb begin
        ftime     = i_data[43:24];
        ftime_x10 = ({4'd0, ftime} << 3) + ({4'd0, ftime} << 1);
        tgt_x11   = ({4'd0, r_target} << 3) + ({4'd0, r_target} << 1) + {4'd0, r_target};
        tgt_x8    = {4'd0, r_target} << 3;
        n_req.op         = t_op'(i_op);
        n_req.ray_count  = i_data[23:0];
        n_req.new_budget = i_data[67:44];
        n_req.slow       = ftime_x10 > tgt_x11;
        n_req.fast       = ftime_x10 < tgt_x8;
    end

    assign o_ready = !r_valid || i_adv;

    // Take a new request whenever the register is empty or the stored one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= n_req;
        end
    end

    assign o_req_valid = r_valid;
    assign o_req       = r_req;

endmodule

>>> src/rbc_core.sv
// State registers, update logic and result register of the ray budget controller.
`timescale 1ns / 1ps

module rbc_core
    import rbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_req i_req,
    output logic o_adv,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    logic [23:0] r_budget;
    logic [31:0] r_spent;
    logic [31:0] r_debt;
    logic [31:0] r_frames;
    logic        r_out_valid;
    t_rsp        r_rsp;

    logic [23:0] n_budget;
    logic [31:0] n_spent;
    logic [31:0] n_debt;
    logic [31:0] n_frames;
    logic        n_grant;

    logic        fire;
    logic [63:0] pay_prod;
    logic [29:0] pay;
    logic [27:0] b_x9;
    logic [28:0] b_x21;
    logic [26:0] scale_in;
    logic [63:0] scale_prod;
    logic [24:0] scaled;
    logic [24:0] adj;
    logic [32:0] need;
    logic [32:0] have;

    assign o_adv = !r_out_valid || i_rsp_ready;
    assign fire  = i_req_valid && o_adv;

    // Pay back one fifth of the debt: reciprocal multiply
    always_comb begin
        pay_prod = {32'd0, r_debt} * {32'd0, DIV5_RECIP};
        pay      = pay_prod[63:DIV5_SHIFT];
    end

    // Budget*9/10 is (budget*9/2)/5, budget*21/20 is (budget*21/4)/5: share one multiply
    always_comb begin
        b_x9       = ({4'd0, r_budget} << 3) + {4'd0, r_budget};
        b_x21      = ({5'd0, r_budget} << 4) + ({5'd0, r_budget} << 2) + {5'd0, r_budget};
        scale_in   = i_req.slow ? b_x9[27:1] : b_x21[28:2];
        scale_prod = {37'd0, scale_in} * {32'd0, DIV5_RECIP};
        scaled     = scale_prod[58:DIV5_SHIFT];
        if (i_req.slow || i_req.fast) begin
            adj = scaled;
        end else begin
            adj = {1'b0, r_budget};
        end
    end

    // Compare the rays asked for against one and a half budgets, no wrap
    always_comb begin
        need = {1'b0, r_spent} + {9'd0, i_req.ray_count};
        have = {9'd0, r_budget} + {10'd0, r_budget[23:1]};
    end

    // Next state for the request in hand
    always_comb begin
        n_budget = r_budget;
        n_spent  = r_spent;
        n_debt   = r_debt;
        n_frames = r_frames;
        n_grant  = 1'b0;
        unique case (i_req.op)
            OP_BEGIN: begin
                n_spent  = 32'd0;
                n_frames = r_frames + 32'd1;
                n_debt   = r_debt - {2'd0, pay};
                n_budget = (pay <= {6'd0, r_budget}) ? r_budget - pay[23:0] : 24'd0;
            end
            OP_END: begin
                if (adj < BUDGET_MIN) begin
                    n_budget = BUDGET_MIN[23:0];
                end else if (adj > BUDGET_MAX) begin
                    n_budget = BUDGET_MAX[23:0];
                end else begin
                    n_budget = adj[23:0];
                end
            end
            OP_QUERY: begin
                n_grant = need <= have;
            end
            OP_SPEND: begin
                n_spent = sat_add32(r_spent, i_req.ray_count);
            end
            OP_BORROW: begin
                n_debt = sat_add32(r_debt, i_req.ray_count);
            end
            OP_SET: begin
                n_budget = i_req.new_budget;
            end
            default: begin
                n_grant = 1'b0;
            end
        endcase
    end

    // Advance the state and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget    <= BUDGET_RESET;
            r_spent     <= 32'd0;
            r_debt      <= 32'd0;
            r_frames    <= 32'd0;
            r_out_valid <= 1'b0;
            r_rsp       <= '{1'b0, BUDGET_RESET, 32'd0, 32'd0, 32'd0};
        end else begin
            if (o_adv) begin
                r_out_valid <= i_req_valid;
            end
            if (fire) begin
                r_budget <= n_budget;
                r_spent  <= n_spent;
                r_debt   <= n_debt;
                r_frames <= n_frames;
                r_rsp    <= '{n_grant, n_budget, n_spent, n_debt, n_frames};
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule

>>> src/ray_budget_controller.sv
// Top level of the ray budget controller: stream ports, input stage and core.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------------
//  s_axis   | in        | tvalid / tready           | tuser op, tdata count/time/budget
//  m_axis   | out       | tvalid / tready           | tdata grant and state after request
//  cfg      | in        | wr_en, no wait            | target frame time in us
//
// One request per cycle while m_axis takes results; a request passes the input register, then the result register.
// The state update is one pass of logic: a 32x32 reciprocal multiply for the debt share,
// a shared 27x32 one for the end frame scaling.
// Reset is synchronous, active low; state returns to budget 4000000, all counts zero.
// A stalled result holds the result register; the input register then fills and tready drops.
`timescale 1ns / 1ps

module ray_budget_controller
    import rbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [19:0]           i_cfg_wr_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [23:0] ray_count, [43:24] frame_time_us, [67:44] new_budget, [71:68] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] may_trace, [24:1] budget_now, [56:25] rays_spent, [88:57] debt_now,
    // [120:89] frame_count, [127:121] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic s_in_valid;
    logic s_adv;
    t_req s_req;
    t_rsp s_rsp;

    rbc_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_op          (i_s_axis_tuser),
        .i_data        (i_s_axis_tdata),
        .i_adv         (s_adv),
        .o_req_valid   (s_in_valid),
        .o_req         (s_req)
    );

    rbc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_in_valid),
        .i_req       (s_req),
        .o_adv       (s_adv),
        .o_rsp_valid (o_m_axis_tvalid),
        .i_rsp_ready (i_m_axis_tready),
        .o_rsp       (s_rsp)
    );

    // Pack the result fields, first field lowest
    assign o_m_axis_tdata = {7'd0, s_rsp.frame_count, s_rsp.debt_now, s_rsp.rays_spent,
                             s_rsp.budget_now, s_rsp.may_trace};

`ifndef SYNTH
    // A request held in the input register stays put until the core takes it
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_valid && !s_adv |=> s_in_valid && $stable(s_req))
        else $error("input request changed while stalled");

    // The frame count on the result changes only by one step
    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (s_rsp.frame_count != $past(s_rsp.frame_count))
        |-> s_rsp.frame_count == $past(s_rsp.frame_count) + 32'd1)
        else $error("frame count jumped");

    // Back-pressure on the input only while a request is waiting
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> s_in_valid && o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without a waiting request");
`endif

endmodule
